>>> rtl/fnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnd_pkg
// Shared types and fixed constants of the fuzzy neighbor decision block.
// ----------------------------------------------------------------------------
package fnd_pkg;

  localparam int DEG_W = 16;
  localparam int SUM_W = 23;
  localparam int CNT_W = 8;
  localparam int REG_W = 16;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_DISP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_COUNT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_C_LOW  = 3'd2;
  localparam logic [IDX_W-1:0] REG_C_MID  = 3'd3;
  localparam logic [IDX_W-1:0] REG_C_HIGH = 3'd4;

  typedef struct packed {
    logic [DEG_W-1:0] nb_high_disp;
    logic [DEG_W-1:0] nb_low_disp;
    logic [DEG_W-1:0] nb_high_msgs;
    logic [DEG_W-1:0] nb_low_msgs;
  } in_word_t;

  typedef struct packed {
    logic [7:0] decision;
    logic       no_rule_fired;
    logic       count_saturated;
  } out_word_t;

  // serial divider control
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

>>> rtl/fnd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnd_in_if / fnd_out_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface fnd_in_if;
  logic              valid;
  logic              ready;
  fnd_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fnd_out_if;
  logic               valid;
  logic               ready;
  fnd_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/fnd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnd_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module fnd_div #(
  parameter int NW = 32,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign diff  = trial - {1'b0, d};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      d   <= den;
      rem <= '0;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem <= diff;
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/fuzzy_neighbor_decision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_neighbor_decision
// Accumulates neighbor membership reports and forms a fuzzy decision.
//
// Channels: in_ch takes one neighbor report word (four Q1.15 degrees),
// out_ch gives one result word per report (decision, no_rule_fired,
// count_saturated). Both are valid/ready; a word moves when both are high.
// Configuration: cfg_we/cfg_idx/cfg_data write registers 0..4; the user
// must write them only while idle, as the block does not enforce this.
// Each report is processed one at a time. Four averages and the dispersion
// trapezoid run through one bit-serial divider, then rule evaluation and,
// when a rule fires, a final division of the weighted centroid sum.
// Reset clears the count, the sums and the result valid and loads the
// centroid defaults. A stalled receiver holds the result; the next report is
// taken and processed while that result waits, then the input stalls.
// ----------------------------------------------------------------------------
module fuzzy_neighbor_decision #(
  parameter int MAX_REPORTS = 255,
  parameter int FRAC_BITS   = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fnd_pkg::IDX_W-1:0]         cfg_idx,
  input  logic [fnd_pkg::REG_W-1:0]         cfg_data,
  fnd_in_if.sink                            in_ch,
  fnd_out_if.source                         out_ch
);

  localparam int SW    = fnd_pkg::SUM_W;
  localparam int DW    = fnd_pkg::DEG_W;
  localparam int ONE   = 1 << FRAC_BITS;
  localparam int T_LO  = (3 * ONE + 5) / 10;
  localparam int T_HI  = (8 * ONE + 5) / 10;
  localparam int D_LO  = (52 * ONE + 50) / 100;
  localparam int D_HI  = (54 * ONE + 50) / 100;
  localparam int SW_W  = 18;
  localparam int NUM_W = 27;
  localparam int DEN_W = 18;
  localparam logic [2:0] SEL_DISP = 3'd4;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ACC  = 7'b0000010,
    S_AVG  = 7'b0000100,
    S_AWT  = 7'b0001000,
    S_RULE = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  logic [DW-1:0]  local_dispersion;
  logic [7:0]     local_message_count;
  logic [7:0]     centroid_low, centroid_mid, centroid_high;
  logic [7:0]     report_count;
  logic [SW-1:0]  sums [4];
  fnd_pkg::in_word_t rep;
  logic           sat;
  logic [2:0]     sel;
  logic [SW_W-1:0] most [4];
  logic [SW_W-1:0] dl_q;
  logic [SW_W-1:0] dl, dh, nl, nh;
  logic [SW_W-1:0] s_low, s_mid, s_high;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [1:0]     rstep;
  logic           disp_band;

  fnd_pkg::div_ctl_t dctl;
  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] div_den;
  logic [NUM_W-1:0] div_quo;
  logic           out_valid;
  fnd_pkg::out_word_t out_word;
  fnd_pkg::out_word_t res;

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_dispersion    <= '0;
      local_message_count <= '0;
      centroid_low        <= 8'd22;
      centroid_mid        <= 8'd50;
      centroid_high       <= 8'd79;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fnd_pkg::REG_DISP:   local_dispersion    <= cfg_data;
        fnd_pkg::REG_COUNT:  local_message_count <= cfg_data[7:0];
        fnd_pkg::REG_C_LOW:  centroid_low        <= cfg_data[7:0];
        fnd_pkg::REG_C_MID:  centroid_mid        <= cfg_data[7:0];
        fnd_pkg::REG_C_HIGH: centroid_high       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  function automatic logic [SW-1:0] clamp1(input logic [DW-1:0] v);
    return (32'(v) > ONE) ? SW'(ONE) : SW'(v);
  endfunction

  function automatic logic [SW_W-1:0] ramp(input logic [SW-1:0] a);
    logic [SW:0] t;
    t = {(SW+1){1'b0}};
    if (32'(a) <= T_LO) return '0;
    if (32'(a) >= T_HI) return SW_W'(ONE);
    t = ({1'b0, a} - (SW+1)'(T_LO)) << 1;
    return (32'(t) > ONE) ? SW_W'(ONE) : SW_W'(t);
  endfunction

  function automatic logic [SW_W-1:0] mn4(input logic [SW_W-1:0] a, b, c, d);
    logic [SW_W-1:0] x, y;
    x = (a < b) ? a : b;
    y = (c < d) ? c : d;
    return (x < y) ? x : y;
  endfunction

  function automatic logic [SW_W-1:0] mx(input logic [SW_W-1:0] a, b);
    return (a > b) ? a : b;
  endfunction

  assign disp_band = (32'(local_dispersion) > D_LO) && (32'(local_dispersion) <= D_HI);

  // one shared divider: averages, dispersion trapezoid and the final quotient
  always_comb begin
    div_num = num_r;
    div_den = NUM_W'(den_r);
    if (state == S_AVG) begin
      if (sel == SEL_DISP) begin
        div_num = disp_band ?
                  (NUM_W'(D_HI - 32'(local_dispersion)) << FRAC_BITS) : '0;
        div_den = NUM_W'(D_HI - D_LO);
      end else begin
        div_num = NUM_W'(sums[sel[1:0]]);
        div_den = (report_count == 8'd0) ? NUM_W'(1) : NUM_W'(report_count);
      end
    end
  end

  fnd_div #(.NW(NUM_W), .DW(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dctl.start),
    .num   (div_num),
    .den   (div_den),
    .busy  (dctl.busy),
    .done  (dctl.done),
    .quo   (div_quo)
  );

  assign dctl.start = (state == S_AVG) ||
                      (state == S_RULE && rstep == 2'd3 && den_r != '0);

  logic [SW_W-1:0] t_low, t_mid, t_high;
  always_comb begin
    t_low = mn4(dl, nl, most[1], most[3]);
    t_low = mx(t_low, mn4(dl, nl, most[1], most[2]));
    t_low = mx(t_low, mn4(dl, nl, most[0], most[3]));
    t_low = mx(t_low, mn4(dl, nh, most[1], most[3]));
    t_mid = mn4(dl, nl, most[0], most[2]);
    t_mid = mx(t_mid, mn4(dl, nh, most[0], most[3]));
    t_mid = mx(t_mid, mn4(dl, nh, most[0], most[2]));
    t_mid = mx(t_mid, mn4(dh, nl, most[1], most[3]));
    t_mid = mx(t_mid, mn4(dh, nl, most[1], most[2]));
    t_high = mn4(dh, nl, most[0], most[3]);
    t_high = mx(t_high, mn4(dh, nl, most[0], most[2]));
    t_high = mx(t_high, mn4(dh, nh, most[1], most[3]));
    t_high = mx(t_high, mn4(dh, nh, most[1], most[2]));
    t_high = mx(t_high, mn4(dh, nh, most[0], most[3]));
    t_high = mx(t_high, mn4(dh, nh, most[0], most[2]));
  end

  logic [SW_W-1:0] dl_v, nl_v;
  always_comb begin
    if (disp_band) dl_v = dl_q;
    else if (32'(local_dispersion) <= D_LO) dl_v = SW_W'(ONE);
    else dl_v = '0;
    if (local_message_count <= 8'd1) nl_v = SW_W'(ONE);
    else if (local_message_count == 8'd2) nl_v = SW_W'(ONE / 2);
    else nl_v = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
      out_word  <= res;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      report_count <= '0;
      for (int i = 0; i < 4; i++) sums[i] <= '0;
      sel          <= '0;
      rstep        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            rep   <= in_ch.data;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (32'(report_count) >= MAX_REPORTS) begin
            sat <= 1'b1;
          end else begin
            sat          <= 1'b0;
            report_count <= report_count + 8'd1;
            sums[0] <= sums[0] + clamp1(rep.nb_high_disp);
            sums[1] <= sums[1] + clamp1(rep.nb_low_disp);
            sums[2] <= sums[2] + clamp1(rep.nb_high_msgs);
            sums[3] <= sums[3] + clamp1(rep.nb_low_msgs);
          end
          sel   <= '0;
          state <= S_AVG;
        end
        S_AVG: state <= S_AWT;
        S_AWT: begin
          if (dctl.done) begin
            sel <= sel + 3'd1;
            if (sel == SEL_DISP) begin
              dl_q  <= div_quo[SW_W-1:0];
              rstep <= '0;
              state <= S_RULE;
            end else begin
              most[sel[1:0]] <= ramp(div_quo[SW-1:0]);
              state          <= S_AVG;
            end
          end
        end
        S_RULE: begin
          rstep <= rstep + 2'd1;
          case (rstep)
            2'd0: begin
              dl <= dl_v;
              dh <= SW_W'(ONE) - dl_v;
              nl <= nl_v;
              nh <= SW_W'(ONE) - nl_v;
            end
            2'd1: begin
              s_low  <= t_low;
              s_mid  <= t_mid;
              s_high <= t_high;
            end
            2'd2: begin
              num_r <= NUM_W'(centroid_low) * NUM_W'(s_low)
                     + NUM_W'(centroid_mid) * NUM_W'(s_mid)
                     + NUM_W'(centroid_high) * NUM_W'(s_high);
              den_r <= DEN_W'(s_low) + DEN_W'(s_mid) + DEN_W'(s_high);
            end
            default: begin
              if (den_r == '0) begin
                res.decision        <= '0;
                res.no_rule_fired   <= 1'b1;
                res.count_saturated <= sat;
                state               <= S_OUT;
              end else begin
                state <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          if (dctl.done) begin
            res.decision        <= div_quo[7:0];
            res.no_rule_fired   <= 1'b0;
            res.count_saturated <= sat;
            state               <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/sv/fuzzy_neighbor_decision_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_neighbor_decision_tb
// Drives neighbor reports through the fuzzy decision block under several
// idle/stall mixes and register settings. A scoreboard predicts each decision
// from its own copy of the sums and settings and checks every result word.
// ----------------------------------------------------------------------------
module fuzzy_neighbor_decision_tb;

  localparam int MAXR = 255;
  localparam int ONE = 32768;
  localparam int T_LO = (3 * ONE + 5) / 10;
  localparam int T_HI = (8 * ONE + 5) / 10;
  localparam int D_LO = (52 * ONE + 50) / 100;
  localparam int D_HI = (54 * ONE + 50) / 100;
  localparam logic [15:0] ONE_D = 16'(ONE);
  localparam longint LIMIT = 2000000;

  class decision_board;
    bit [15:0] disp;
    bit [7:0] msgs, c_lo, c_mid, c_hi;
    bit [7:0] reports;
    bit [22:0] sums [4];
    fnd_pkg::out_word_t pending [$];
    int errors;
    int matched;
    int saturated_seen;
    int none_seen;

    function new();
      disp = 0; msgs = 0; c_lo = 22; c_mid = 50; c_hi = 79; reports = 0;
      foreach (sums[i]) sums[i] = 0;
      errors = 0; matched = 0; saturated_seen = 0; none_seen = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [15:0] v);
      case (idx)
        fnd_pkg::REG_DISP:   disp = v;
        fnd_pkg::REG_COUNT:  msgs = v[7:0];
        fnd_pkg::REG_C_LOW:  c_lo = v[7:0];
        fnd_pkg::REG_C_MID:  c_mid = v[7:0];
        fnd_pkg::REG_C_HIGH: c_hi = v[7:0];
        default: ;
      endcase
    endfunction

    function int ramp(int avg);
      int r;
      if (avg <= T_LO) return 0;
      if (avg >= T_HI) return ONE;
      r = 2 * (avg - T_LO);
      return r > ONE ? ONE : r;
    endfunction

    function int mn4(int a, int b, int c, int d);
      int m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      if (d < m) m = d;
      return m;
    endfunction

    function int mx(int a, int b);
      return a > b ? a : b;
    endfunction

    function void note_report(fnd_pkg::in_word_t w);
      bit [15:0] deg [4];
      int m [2][2];
      int dd [2], nn [2];
      int cnt, sl, sm, sh, d;
      longint num, den;
      fnd_pkg::out_word_t r;
      deg[0] = w.nb_high_disp; deg[1] = w.nb_low_disp;
      deg[2] = w.nb_high_msgs; deg[3] = w.nb_low_msgs;
      r = '0;
      if (reports >= MAXR) r.count_saturated = 1'b1;
      else begin
        reports++;
        foreach (sums[i]) sums[i] += 23'((deg[i] > ONE) ? ONE : deg[i]);
      end
      cnt = reports ? reports : 1;
      // m[0]=dispersion, m[1]=count; index 1 high, 0 low
      m[0][1] = ramp(sums[0] / cnt); m[0][0] = ramp(sums[1] / cnt);
      m[1][1] = ramp(sums[2] / cnt); m[1][0] = ramp(sums[3] / cnt);
      if (disp <= D_LO) dd[0] = ONE;
      else if (disp <= D_HI) dd[0] = ((D_HI - disp) * ONE) / (D_HI - D_LO);
      else dd[0] = 0;
      dd[1] = ONE - dd[0];
      if (msgs <= 1) nn[0] = ONE;
      else if (msgs <= 3) nn[0] = ((3 - msgs) * ONE) / 2;
      else nn[0] = 0;
      nn[1] = ONE - nn[0];
      sl = 0; sm = 0; sh = 0;
      for (int a = 0; a < 2; a++)
        for (int b = 0; b < 2; b++)
          for (int c = 0; c < 2; c++)
            for (int e = 0; e < 2; e++) begin
              d = mn4(dd[a], nn[b], m[0][c], m[1][e]);
              case ({a[0], b[0], c[0], e[0]})
                4'b0000, 4'b0001, 4'b0010, 4'b0100: sl = mx(sl, d);
                4'b0011, 4'b0110, 4'b0111, 4'b1000, 4'b1001: sm = mx(sm, d);
                4'b0101: ;
                default: sh = mx(sh, d);
              endcase
            end
      den = longint'(sl) + sm + sh;
      num = longint'(c_lo) * sl + longint'(c_mid) * sm + longint'(c_hi) * sh;
      if (den == 0) r.no_rule_fired = 1'b1;
      else r.decision = 8'(num / den);
      pending.push_back(r);
    endfunction

    function void check_result(fnd_pkg::out_word_t got);
      fnd_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.decision !== exp_w.decision)
        $display("%0t: decision expected %0d actual %0d", $time, exp_w.decision,
                 got.decision);
      if (got.no_rule_fired !== exp_w.no_rule_fired)
        $display("%0t: no_rule_fired expected %b actual %b", $time,
                 exp_w.no_rule_fired, got.no_rule_fired);
      if (got.count_saturated !== exp_w.count_saturated)
        $display("%0t: count_saturated expected %b actual %b", $time,
                 exp_w.count_saturated, got.count_saturated);
      if (got !== exp_w) errors++;
      else matched++;
      if (got.count_saturated === 1'b1) saturated_seen++;
      if (got.no_rule_fired === 1'b1) none_seen++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [fnd_pkg::IDX_W-1:0] cfg_idx = '0;
  logic [fnd_pkg::REG_W-1:0] cfg_data = '0;
  fnd_in_if in_ch ();
  fnd_out_if out_ch ();

  decision_board board = new();
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;
  longint cycles = 0;
  int sent = 0;

  fuzzy_neighbor_decision dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver and scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic [15:0] pick_degree();
    case ($urandom_range(9))
      0: return '0;
      1: return ONE_D;
      2: return 16'($urandom);
      default: return 16'($urandom_range(ONE));
    endcase
  endfunction

  // valid stays high after an accept until the next word or drain()
  task automatic send_report(fnd_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_report(w);
    sent++;
  endtask

  task automatic send_random(int n);
    fnd_pkg::in_word_t w;
    repeat (n) begin
      w.nb_high_disp = pick_degree();
      w.nb_low_disp = pick_degree();
      w.nb_high_msgs = pick_degree();
      w.nb_low_msgs = pick_degree();
      send_report(w);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [fnd_pkg::IDX_W-1:0] idx,
                           logic [fnd_pkg::REG_W-1:0] v);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    board.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic settings(logic [15:0] d, logic [7:0] m, logic [7:0] lo,
                          logic [7:0] md, logic [7:0] hi);
    write_reg(fnd_pkg::REG_DISP, d);
    write_reg(fnd_pkg::REG_COUNT, 16'(m));
    write_reg(fnd_pkg::REG_C_LOW, 16'(lo));
    write_reg(fnd_pkg::REG_C_MID, 16'(md));
    write_reg(fnd_pkg::REG_C_HIGH, 16'(hi));
  endtask

  task automatic random_settings();
    logic [15:0] d;
    case ($urandom_range(3))
      0: d = 16'($urandom_range(D_HI + 2, D_LO - 2));
      1: d = 16'($urandom);
      default: d = 16'($urandom_range(ONE));
    endcase
    settings(d, 8'($urandom_range(5)), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    fnd_pkg::in_word_t w;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, extremes, above-one degrees
    w = '{ONE_D, '0, ONE_D, '0};   send_report(w);
    w = '{'0, ONE_D, '0, ONE_D};   send_report(w);
    w = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}; send_report(w);
    w = '{'0, '0, '0, '0};         send_report(w);
    w = '{16'h5555, 16'hAAAA, 16'h8001, 16'h7FFF}; send_report(w);
    drain();
    // unknown index is ignored
    write_reg(3'd7, 16'hFFFF);
    write_reg(3'd5, 16'h1234);
    settings(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    w = '{ONE_D, ONE_D, ONE_D, ONE_D}; send_report(w);
    w = '{'0, '0, '0, '0};         send_report(w);
    drain();
    settings(16'(D_LO + 300), 8'd2, 8'd0, 8'd0, 8'd0);
    w = '{ONE_D, '0, '0, ONE_D};   send_report(w);
    drain();
    settings(16'(D_HI), 8'd3, 8'd22, 8'd50, 8'd79);
    send_random(8);
    drain();

    // saturate the report count, with a long receiver hold-off
    settings(16'(D_LO), 8'd1, 8'd10, 8'd128, 8'd250);
    fork
      send_random(300);
      begin
        repeat (50) @(posedge clk);
        hold_off = 1;
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end
    join
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 49; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 49; end
        default: begin send_idle = 35; recv_stall = 35; end
      endcase
      random_settings();
      send_random(110);
      drain();
    end
    if (board.pending.size() != 0) board.errors++;

    $display("Sent %0d reports, %0d results matched; %0d saturated, %0d with no rule.",
             sent, board.matched, board.saturated_seen, board.none_seen);
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
